// ----- rtl/cdc_pkg.sv -----
// Shared types and constants for the content-defined chunker.
package cdc_pkg;

  localparam int unsigned AvgW = 25;
  localparam int unsigned SpanW = 24;
  localparam int unsigned BufW = 32;
  localparam int unsigned HashW = 64;
  localparam int unsigned LenW = 25;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ModCntW = 6;

  localparam logic [AvgW-1:0] AVG_RESET = 25'd4096;
  localparam logic [SpanW-1:0] MIN_RESET = 24'd1024;
  localparam logic [SpanW-1:0] MAX_RESET = 24'd16384;
  localparam logic [BufW-1:0] BUF_RESET = 32'd0;

  localparam logic [CfgIdxW-1:0] CFG_AVG_SIZE = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_SPAN = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPAN = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_BUFFER_SIZE = 8'd3;

  typedef enum logic [1:0] {
    REASON_HASH = 2'd0,
    REASON_MAX = 2'd1,
    REASON_BUFFER = 2'd2,
    REASON_EOD = 2'd3
  } cdc_reason_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_DONE
  } cdc_state_t;

  typedef struct packed {
    logic done;
    logic zero;
  } cdc_mod_stat_t;

  // Multiply by 0x100000001B3 modulo 2^64, written as shifts and adds, then add the byte.
  function automatic logic [HashW-1:0] hash_step(input logic [HashW-1:0] h,
                                                 input logic [7:0] b);
    hash_step = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4)
              + (h << 1) + h + {56'd0, b};
  endfunction

endpackage

// ----- rtl/cdc_if.sv -----
// Valid/ready channel interfaces for the chunker's input bytes and chunk results.
interface cdc_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic end_of_data;
  modport source(output valid, data_byte, end_of_data, input ready);
  modport sink(input valid, data_byte, end_of_data, output ready);
endinterface

interface cdc_out_if;
  logic valid;
  logic ready;
  logic [cdc_pkg::LenW-1:0] chunk_length;
  logic [1:0] end_reason;
  logic final_chunk;
  modport source(output valid, chunk_length, end_reason, final_chunk, input ready);
  modport sink(input valid, chunk_length, end_reason, final_chunk, output ready);
endinterface

// ----- rtl/content_defined_chunker.sv -----
// Content-defined chunker: one byte per item, one result per closed chunk.
// An item passes IDLE, HASH and DONE, its result registered as it commits from DONE, when no remainder
// test is needed (power-of-two average, or span outside the hash window); it also
// waits in MOD while the bit-serial unit reduces the hash modulo the average.
// One item is in work at a time; a cutting item waits in DONE, before commit, while a result is held.
// Synchronous reset restores the register defaults and zeroes state.
module content_defined_chunker (
  input  logic                           clk,
  input  logic                           rst,
  cdc_in_if.sink                         data_in,
  cdc_out_if.source                      chunk_out,
  input  logic                           cfg_we,
  input  logic [cdc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [cdc_pkg::CfgDataW-1:0]   cfg_data
);

  cdc_pkg::cdc_state_t state, state_next;

  logic [cdc_pkg::AvgW-1:0] avg_size;
  logic [cdc_pkg::SpanW-1:0] min_span;
  logic [cdc_pkg::SpanW-1:0] max_span;
  logic [cdc_pkg::BufW-1:0] buffer_size;

  logic [cdc_pkg::HashW-1:0] running_hash;
  logic [cdc_pkg::HashW-1:0] running_hash_next;
  logic [cdc_pkg::SpanW-1:0] chunk_span;
  logic [cdc_pkg::BufW-1:0] buffer_fill;

  logic [7:0] byte_q;
  logic eod_q;

  logic out_valid;
  logic [cdc_pkg::LenW-1:0] out_length;
  cdc_pkg::cdc_reason_t out_reason;
  logic out_final;

  cdc_pkg::cdc_mod_stat_t mod_stat;
  logic mod_start;
  logic commit;
  logic accept;

  logic avg_zero;
  logic avg_pow2;
  logic span_ge_min;
  logic span_ge_max;
  logic buf_end;
  logic mask_hit;
  logic hash_hit;
  logic need_mod;
  logic cut;
  cdc_pkg::cdc_reason_t reason;

  assign running_hash_next = cdc_pkg::hash_step(running_hash, byte_q);

  always_comb begin
    avg_zero = (avg_size == '0);
    avg_pow2 = ((avg_size & (avg_size - 1'b1)) == '0);
    span_ge_min = (chunk_span >= min_span);
    span_ge_max = (chunk_span >= max_span);
    buf_end = (buffer_size != '0)
           && ({1'b0, buffer_fill} + 33'd1 == {1'b0, buffer_size});
    mask_hit = ((running_hash[cdc_pkg::AvgW-1:0] & (avg_size - 1'b1)) == '0);
    hash_hit = !avg_zero && (avg_pow2 ? mask_hit : mod_stat.zero);
    need_mod = span_ge_min && !span_ge_max && !avg_zero && !avg_pow2;
    cut = 1'b0;
    reason = cdc_pkg::REASON_HASH;
    if (span_ge_min && span_ge_max) begin
      cut = 1'b1;
      reason = cdc_pkg::REASON_MAX;
    end else if (span_ge_min && hash_hit) begin
      cut = 1'b1;
      reason = cdc_pkg::REASON_HASH;
    end else if (eod_q) begin
      cut = 1'b1;
      reason = cdc_pkg::REASON_EOD;
    end else if (buf_end) begin
      cut = 1'b1;
      reason = cdc_pkg::REASON_BUFFER;
    end
  end

  always_comb begin
    state_next = state;
    mod_start = 1'b0;
    commit = 1'b0;
    accept = 1'b0;
    unique case (state)
      cdc_pkg::ST_IDLE: begin
        accept = data_in.valid;
        if (data_in.valid) begin
          state_next = cdc_pkg::ST_HASH;
        end
      end
      cdc_pkg::ST_HASH: begin
        if (need_mod) begin
          mod_start = 1'b1;
          state_next = cdc_pkg::ST_MOD;
        end else begin
          state_next = cdc_pkg::ST_DONE;
        end
      end
      cdc_pkg::ST_MOD: begin
        if (mod_stat.done) begin
          state_next = cdc_pkg::ST_DONE;
        end
      end
      cdc_pkg::ST_DONE: begin
        if (!cut || !out_valid || chunk_out.ready) begin
          commit = 1'b1;
          state_next = cdc_pkg::ST_IDLE;
        end
      end
      default: state_next = cdc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_size <= cdc_pkg::AVG_RESET;
      min_span <= cdc_pkg::MIN_RESET;
      max_span <= cdc_pkg::MAX_RESET;
      buffer_size <= cdc_pkg::BUF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdc_pkg::CFG_AVG_SIZE:    avg_size <= cfg_data[cdc_pkg::AvgW-1:0];
        cdc_pkg::CFG_MIN_SPAN:    min_span <= cfg_data[cdc_pkg::SpanW-1:0];
        cdc_pkg::CFG_MAX_SPAN:    max_span <= cfg_data[cdc_pkg::SpanW-1:0];
        cdc_pkg::CFG_BUFFER_SIZE: buffer_size <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      chunk_span <= '0;
      buffer_fill <= '0;
    end else begin
      if (state == cdc_pkg::ST_HASH) begin
        running_hash <= running_hash_next;
      end
      if (commit) begin
        if (cut) begin
          running_hash <= '0;
          chunk_span <= '0;
        end else begin
          chunk_span <= chunk_span + 1'b1;
        end
        if (eod_q || buf_end) begin
          buffer_fill <= '0;
        end else begin
          buffer_fill <= buffer_fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= data_in.data_byte;
      eod_q <= data_in.end_of_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && cut) begin
      out_valid <= 1'b1;
    end else if (chunk_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && cut) begin
      out_length <= {1'b0, chunk_span} + 25'd1;
      out_reason <= reason;
      out_final <= eod_q;
    end
  end

  cdc_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (running_hash_next),
    .divisor  (avg_size),
    .stat     (mod_stat)
  );

  assign data_in.ready = (state == cdc_pkg::ST_IDLE);
  assign chunk_out.valid = out_valid;
  assign chunk_out.chunk_length = out_length;
  assign chunk_out.end_reason = out_reason;
  assign chunk_out.final_chunk = out_final;

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    data_in.valid && data_in.ready |=> !data_in.ready)
    else $error("input accepted while an item is in work");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    chunk_out.valid |-> chunk_out.chunk_length != '0)
    else $error("chunk of zero length");

  a_eod_final: assert property (@(posedge clk) disable iff (rst)
    chunk_out.valid && chunk_out.end_reason == cdc_pkg::REASON_EOD |-> chunk_out.final_chunk)
    else $error("end-of-data chunk not marked final");

  a_mod_wait: assert property (@(posedge clk) disable iff (rst)
    state == cdc_pkg::ST_MOD && !mod_stat.done |=> state == cdc_pkg::ST_MOD)
    else $error("left remainder wait before the unit finished");
`endif

endmodule

// ----- rtl/cdc_mod_unit.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module cdc_mod_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cdc_pkg::HashW-1:0]     dividend,
  input  logic [cdc_pkg::AvgW-1:0]      divisor,
  output cdc_pkg::cdc_mod_stat_t        stat
);

  logic [cdc_pkg::HashW-1:0] quo;
  logic [cdc_pkg::AvgW-1:0] dvs;
  logic [cdc_pkg::AvgW-1:0] rem;
  logic [cdc_pkg::AvgW-1:0] rem_next;
  logic [cdc_pkg::ModCntW-1:0] cnt;
  logic busy;
  logic done;
  logic [cdc_pkg::AvgW:0] rem_sh;
  logic [cdc_pkg::AvgW:0] diff;

  always_comb begin
    rem_sh = {rem, quo[cdc_pkg::HashW-1]};
    diff = rem_sh - {1'b0, dvs};
    if (rem_sh >= {1'b0, dvs}) begin
      rem_next = diff[cdc_pkg::AvgW-1:0];
    end else begin
      rem_next = rem_sh[cdc_pkg::AvgW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= '1;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= quo << 1;
      rem <= rem_next;
    end
  end

  assign stat.done = done;
  assign stat.zero = (rem == '0);

endmodule
